[src/cue_chime_generator_unit_defines.svh]
// Assertion macros shared by the chime generator's checker.
`ifndef CUE_CHIME_GENERATOR_UNIT_DEFINES_SVH
`define CUE_CHIME_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CCG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ccg_pkg.sv]
// Types, constants and sine tables of the cue chime generator.
package ccg_pkg;

   // Command codes on the request channel.
   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_READY     = 3'd1;
   localparam logic [2:0] CMD_UNPAIRED  = 3'd2;
   localparam logic [2:0] CMD_RECONNECT = 3'd3;
   localparam logic [2:0] CMD_CLEAR     = 3'd4;

   // Cue kinds.
   localparam logic [1:0] KIND_READY     = 2'd0;
   localparam logic [1:0] KIND_UNPAIRED  = 2'd1;
   localparam logic [1:0] KIND_RECONNECT = 2'd2;

   // Segment lengths in samples.
   localparam logic [11:0] LEADIN_LEN     = 12'd2400;
   localparam logic [11:0] NOTE_LEN       = 12'd1280;
   localparam logic [11:0] GAP_LEN        = 12'd320;
   localparam logic [11:0] TAIL_LEN       = 12'd960;
   localparam logic [11:0] FADE_LEN       = 12'd160;
   localparam logic [11:0] FADE_OUT_START = 12'd1120;

   // Last index of the low-note table.
   localparam logic [4:0] LOW_LAST = 5'd19;

   // Division by 160 is done as a multiply by ceil(2^28 / 160) and a shift by 28.
   localparam int unsigned    RECIP_SHIFT = 28;
   localparam logic [28:0]    FADE_RECIP  = 29'd1677722;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LEADIN = 3'd1,
      PH_NOTE   = 3'd2,
      PH_GAP    = 3'd3,
      PH_TAIL   = 3'd4
   } phase_type;

   // One sample on its way from the sequencer to the scaling stage.
   typedef struct packed {
      logic        valid;
      logic [12:0] mag;
      logic [28:0] scale;
      logic        neg;
      logic        amp_on;
      logic [1:0]  cue_kind;
      logic        cue_last;
      logic        fault;
   } stage_type;

   // Low note: 20 samples per period.
   function automatic logic signed [13:0] low_wave(input logic [4:0] idx);
      logic signed [13:0] w;
      case (idx)
         5'd0:    w = 14'sd0;
         5'd1:    w = 14'sd2472;
         5'd2:    w = 14'sd4702;
         5'd3:    w = 14'sd6472;
         5'd4:    w = 14'sd7608;
         5'd5:    w = 14'sd8000;
         5'd6:    w = 14'sd7608;
         5'd7:    w = 14'sd6472;
         5'd8:    w = 14'sd4702;
         5'd9:    w = 14'sd2472;
         5'd10:   w = 14'sd0;
         5'd11:   w = -14'sd2472;
         5'd12:   w = -14'sd4702;
         5'd13:   w = -14'sd6472;
         5'd14:   w = -14'sd7608;
         5'd15:   w = -14'sd8000;
         5'd16:   w = -14'sd7608;
         5'd17:   w = -14'sd6472;
         5'd18:   w = -14'sd4702;
         5'd19:   w = -14'sd2472;
         default: w = 14'sd0;
      endcase
      return w;
   endfunction

   // High note: 16 samples per period.
   function automatic logic signed [13:0] high_wave(input logic [3:0] idx);
      logic signed [13:0] w;
      case (idx)
         4'd0:    w = 14'sd0;
         4'd1:    w = 14'sd3061;
         4'd2:    w = 14'sd5657;
         4'd3:    w = 14'sd7391;
         4'd4:    w = 14'sd8000;
         4'd5:    w = 14'sd7391;
         4'd6:    w = 14'sd5657;
         4'd7:    w = 14'sd3061;
         4'd8:    w = 14'sd0;
         4'd9:    w = -14'sd3061;
         4'd10:   w = -14'sd5657;
         4'd11:   w = -14'sd7391;
         4'd12:   w = -14'sd8000;
         4'd13:   w = -14'sd7391;
         4'd14:   w = -14'sd5657;
         4'd15:   w = -14'sd3061;
         default: w = 14'sd0;
      endcase
      return w;
   endfunction

endpackage

[src/ccg_seq.sv]
// Cue sequencer: pending requests, phase counters and the unscaled sample.
module ccg_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [2:0]          command,
   input  logic                speech_busy,
   input  logic                sink_error,
   output ccg_pkg::stage_type  stage_ff
);

   logic                pend_ready_ff, pend_ready_in;
   logic                pend_unpaired_ff, pend_unpaired_in;
   logic                pend_reconnect_ff, pend_reconnect_in;
   logic [1:0]          kind_ff, kind_in;
   ccg_pkg::phase_type  phase_ff, phase_in;
   logic [1:0]          note_ff, note_in;
   logic [11:0]         pos_ff, pos_in;
   logic [4:0]          tab_ff, tab_in;
   ccg_pkg::stage_type  stage_in;

   logic                is_tick;
   logic                idle;
   logic                sel_valid;
   logic [1:0]          sel_kind;
   logic                go;
   ccg_pkg::phase_type  cur_phase;
   logic [1:0]          cur_kind;
   logic [1:0]          cur_note;
   logic [11:0]         cur_pos;
   logic [4:0]          cur_tab;
   logic                tail_end;
   logic                more_notes;
   logic                is_high;
   logic signed [13:0]  wave;
   logic signed [13:0]  wave_neg;
   logic [11:0]         fade_out;
   logic [7:0]          fade;

   // Pick the highest-priority pending cue.
   always_comb begin
      sel_valid = 1'b1;
      sel_kind  = ccg_pkg::KIND_READY;
      if (pend_reconnect_ff) begin
         sel_kind = ccg_pkg::KIND_RECONNECT;
      end else if (pend_unpaired_ff) begin
         sel_kind = ccg_pkg::KIND_UNPAIRED;
      end else if (!pend_ready_ff) begin
         sel_valid = 1'b0;
      end
   end

   // A tick plays a sample if a cue runs or one can start now.
   assign is_tick = (command == ccg_pkg::CMD_TICK);
   assign idle    = (phase_ff == ccg_pkg::PH_IDLE);
   assign go      = is_tick && (!idle || (!speech_busy && sel_valid));

   // Working state for this tick, with a fresh cue starting at lead-in.
   assign cur_phase = idle ? ccg_pkg::PH_LEADIN : phase_ff;
   assign cur_kind  = idle ? sel_kind : kind_ff;
   assign cur_note  = idle ? 2'd0 : note_ff;
   assign cur_pos   = idle ? 12'd0 : pos_ff;
   assign cur_tab   = idle ? 5'd0 : tab_ff;

   assign tail_end   = (cur_phase == ccg_pkg::PH_TAIL) && (cur_pos == ccg_pkg::TAIL_LEN - 12'd1);
   assign more_notes = (cur_kind == ccg_pkg::KIND_RECONNECT) ? (cur_note < 2'd2)
                                                             : (cur_note < 2'd1);

   // Next state of flags and counters.
   always_comb begin
      pend_ready_in     = pend_ready_ff;
      pend_unpaired_in  = pend_unpaired_ff;
      pend_reconnect_in = pend_reconnect_ff;
      kind_in           = kind_ff;
      phase_in          = phase_ff;
      note_in           = note_ff;
      pos_in            = pos_ff;
      tab_in            = tab_ff;
      case (command)
         ccg_pkg::CMD_READY:     pend_ready_in = 1'b1;
         ccg_pkg::CMD_UNPAIRED:  pend_unpaired_in = 1'b1;
         ccg_pkg::CMD_RECONNECT: pend_reconnect_in = 1'b1;
         ccg_pkg::CMD_CLEAR: begin
            pend_ready_in     = 1'b0;
            pend_unpaired_in  = 1'b0;
            pend_reconnect_in = 1'b0;
         end
         ccg_pkg::CMD_TICK: begin
            if (go) begin
               // Starting consumes only the chosen flag.
               if (idle) begin
                  case (sel_kind)
                     ccg_pkg::KIND_RECONNECT: pend_reconnect_in = 1'b0;
                     ccg_pkg::KIND_UNPAIRED:  pend_unpaired_in = 1'b0;
                     default:                 pend_ready_in = 1'b0;
                  endcase
               end
               kind_in  = cur_kind;
               phase_in = cur_phase;
               note_in  = cur_note;
               pos_in   = cur_pos + 12'd1;
               tab_in   = 5'd0;
               if (sink_error || tail_end) begin
                  phase_in = ccg_pkg::PH_IDLE;
                  note_in  = 2'd0;
                  pos_in   = 12'd0;
               end else begin
                  case (cur_phase)
                     ccg_pkg::PH_LEADIN: begin
                        if (cur_pos == ccg_pkg::LEADIN_LEN - 12'd1) begin
                           phase_in = ccg_pkg::PH_NOTE;
                           note_in  = 2'd0;
                           pos_in   = 12'd0;
                        end
                     end
                     ccg_pkg::PH_NOTE: begin
                        if (cur_pos == ccg_pkg::NOTE_LEN - 12'd1) begin
                           phase_in = more_notes ? ccg_pkg::PH_GAP : ccg_pkg::PH_TAIL;
                           pos_in   = 12'd0;
                        end else begin
                           tab_in = (cur_tab == ccg_pkg::LOW_LAST) ? 5'd0 : cur_tab + 5'd1;
                        end
                     end
                     ccg_pkg::PH_GAP: begin
                        if (cur_pos == ccg_pkg::GAP_LEN - 12'd1) begin
                           phase_in = ccg_pkg::PH_NOTE;
                           note_in  = cur_note + 2'd1;
                           pos_in   = 12'd0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end else begin
               phase_in = ccg_pkg::PH_IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   // Note pitch and fade envelope.
   always_comb begin
      case (cur_kind)
         ccg_pkg::KIND_RECONNECT: is_high = (cur_note == 2'd1);
         ccg_pkg::KIND_UNPAIRED:  is_high = (cur_note == 2'd0);
         default:                 is_high = (cur_note != 2'd0);
      endcase
      wave     = is_high ? ccg_pkg::high_wave(cur_pos[3:0]) : ccg_pkg::low_wave(cur_tab);
      wave_neg = -wave;
      fade_out = ccg_pkg::NOTE_LEN - cur_pos;
      if (cur_pos < ccg_pkg::FADE_LEN) begin
         fade = cur_pos[7:0];
      end else if (cur_pos > ccg_pkg::FADE_OUT_START) begin
         fade = fade_out[7:0];
      end else begin
         fade = ccg_pkg::FADE_LEN[7:0];
      end
   end

   // Result fields for the scaling stage.
   always_comb begin
      stage_in          = '0;
      stage_in.valid    = in_valid && go;
      stage_in.cue_kind = cur_kind;
      if (sink_error) begin
         stage_in.cue_last = 1'b1;
         stage_in.fault    = 1'b1;
      end else if (tail_end) begin
         stage_in.cue_last = 1'b1;
      end else begin
         stage_in.amp_on = 1'b1;
         if (cur_phase == ccg_pkg::PH_NOTE) begin
            stage_in.neg   = wave[13];
            stage_in.mag   = wave[13] ? wave_neg[12:0] : wave[12:0];
            stage_in.scale = 29'(fade) * ccg_pkg::FADE_RECIP;
         end
      end
   end

   // State advances on each consumed beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ready_ff     <= 1'b0;
         pend_unpaired_ff  <= 1'b0;
         pend_reconnect_ff <= 1'b0;
         kind_ff           <= ccg_pkg::KIND_READY;
         phase_ff          <= ccg_pkg::PH_IDLE;
         note_ff           <= 2'd0;
         pos_ff            <= 12'd0;
         tab_ff            <= 5'd0;
      end else if (en && in_valid) begin
         pend_ready_ff     <= pend_ready_in;
         pend_unpaired_ff  <= pend_unpaired_in;
         pend_reconnect_ff <= pend_reconnect_in;
         kind_ff           <= kind_in;
         phase_ff          <= phase_in;
         note_ff           <= note_in;
         pos_ff            <= pos_in;
         tab_ff            <= tab_in;
      end
   end

   // Stage register toward the multiplier.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

endmodule

[src/ccg_scale.sv]
// Fade scaling: magnitude times fade over 160, truncated toward zero, into the result register.
module ccg_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  ccg_pkg::stage_type  stage,
   output logic                rsp_valid_ff,
   output logic signed [13:0]  sample_ff,
   output logic                amp_on_ff,
   output logic [1:0]          cue_kind_ff,
   output logic                cue_last_ff,
   output logic                fault_ff
);

   logic [41:0]        prod;
   logic [12:0]        quot;
   logic signed [13:0] quot_s;
   logic signed [13:0] sample_in;

   // The reciprocal product floors exactly for all products up to 8000 * 160.
   always_comb begin
      prod      = 42'(stage.mag) * 42'(stage.scale);
      quot      = prod[ccg_pkg::RECIP_SHIFT +: 13];
      quot_s    = $signed({1'b0, quot});
      sample_in = stage.neg ? -quot_s : quot_s;
   end

   // Result register; holds while the sink stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sample_ff   <= sample_in;
         amp_on_ff   <= stage.amp_on;
         cue_kind_ff <= stage.cue_kind;
         cue_last_ff <= stage.cue_last;
         fault_ff    <= stage.fault;
      end
   end

endmodule

[src/cue_chime_generator_unit.sv]
// Top level of the cue chime generator: input register, sequencer and scaling stage.
// One beat is taken per clock while the sink does not stall, and each sample tick yields its result
// through the input register, the sequencer stage register and then the result register; request,
// clear and idle ticks pass through without a result. The whole pipeline advances together
// whenever the result register is empty or being taken, so a stalled sink holds every
// stage, while an empty input register still takes one more beat. Sustained rate is one
// item per cycle while the sink keeps up, set by the phase counter update in the sequencer.
module cue_chime_generator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] command, [3] speech_busy, [4] sink_error, [7:5] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [13:0] sample, [14] amp_on, [15] fault
   output logic [1:0]  rsp_tuser,   // [1:0] cue_kind
   output logic        rsp_tlast    // cue_last
);

   logic               en;
   logic               in_valid_ff;
   logic [2:0]         command_ff;
   logic               busy_ff;
   logic               serr_ff;
   ccg_pkg::stage_type stage;
   logic               rsp_valid;
   logic signed [13:0] sample;
   logic               amp_on;
   logic [1:0]         cue_kind;
   logic               cue_last;
   logic               fault;

   // Pipeline advance and input readiness.
   assign en         = !rsp_valid || rsp_tready;
   assign req_tready = en || !in_valid_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         command_ff <= req_tdata[2:0];
         busy_ff    <= req_tdata[3];
         serr_ff    <= req_tdata[4];
      end
   end

   ccg_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (in_valid_ff),
      .command     (command_ff),
      .speech_busy (busy_ff),
      .sink_error  (serr_ff),
      .stage_ff    (stage)
   );

   ccg_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .stage        (stage),
      .rsp_valid_ff (rsp_valid),
      .sample_ff    (sample),
      .amp_on_ff    (amp_on),
      .cue_kind_ff  (cue_kind),
      .cue_last_ff  (cue_last),
      .fault_ff     (fault)
   );

   // Result channel packing.
   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {fault, amp_on, sample};
   assign rsp_tuser  = cue_kind;
   assign rsp_tlast  = cue_last;

endmodule

[src/ccg_checker.sv]
// Port-level checker for the cue chime generator, bound to the top level.
`include "cue_chime_generator_unit_defines.svh"

module ccg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result beat holds its contents.
   `CCG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result beat changed while stalled")

   // The amplifier is off exactly on the closing beat of a cue.
   `CCG_ASSERT_NOW(a_amp_last, clock, reset, rsp_tvalid, rsp_tlast == !rsp_tdata[14], "amp_on does not match cue_last")

   // An aborted cue closes on a silent beat.
   `CCG_ASSERT_NOW(a_fault_silent, clock, reset, rsp_tvalid && rsp_tdata[15], rsp_tlast && (rsp_tdata[13:0] == 14'd0), "fault beat is not a silent last beat")

   // No result appears right after reset.
   `CCG_ASSERT_NOW(a_reset_quiet, clock, reset, $past(reset), !rsp_tvalid, "result valid right after reset")

   // Only the three cue kinds are reported.
   `CCG_ASSERT_NOW(a_kind_range, clock, reset, rsp_tvalid, rsp_tuser != 2'd3, "unknown cue kind")

endmodule

bind cue_chime_generator_unit ccg_checker u_ccg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
